>>> rtl/horn_light_output_defines.svh
// Assertion macros for the horn light output RTL, used by hlo_log.
`ifndef HORN_LIGHT_OUTPUT_DEFINES_SVH
`define HORN_LIGHT_OUTPUT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check prop on every clock edge outside reset.
`define HLO_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("horn_light_output assertion failed");
// Check prop on every clock edge, reset included.
`define HLO_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("horn_light_output assertion failed");
`else
`define HLO_ASSERT(name, clk, rst_n, prop)
`define HLO_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> rtl/hlo_pkg.sv
// Types, constants and helper functions for the horn light output block.
package hlo_pkg;

  localparam int unsigned EW   = 24;  // energy, Q12.12
  localparam int unsigned ZW   = 4;
  localparam int unsigned AW   = 7;
  localparam int unsigned PW   = 32;  // Q16.16 parameters
  localparam int unsigned LW   = 48;  // light, Q32.16
  localparam int unsigned KW   = 8;   // A*Z^2 weight
  localparam int unsigned CW   = 40;  // quench term c
  localparam int unsigned E16W = 28;  // energy in Q.16
  localparam int unsigned UW   = 41;  // log argument magnitude
  localparam int unsigned MW   = 32;  // Q1.31 mantissa
  localparam int unsigned KLW  = 6;   // log integer part
  localparam int unsigned FW   = 24;  // log fraction bits
  localparam int unsigned LGW  = KLW + FW;
  localparam int unsigned ROUNDS = FW;
  localparam int unsigned DW   = LGW + 1;
  localparam int unsigned LNW  = 24;  // ln ratio, Q.16
  localparam int unsigned IW   = 49;  // inner term

  localparam logic signed [DW-1:0] LN2_Q30 = 31'sd744261118;
  localparam logic [KLW-1:0] TOP_BIT = 6'd40;

  localparam logic signed [PW-1:0] OFFSET_RST = 32'sd655;
  localparam logic signed [PW-1:0] GAIN_RST   = 32'sd655;
  localparam logic signed [PW-1:0] QUENCH_RST = 32'sd6554;

  localparam logic signed [LW+16:0] LIGHT_MAX = 65'sd140737488355327;
  localparam logic signed [LW+16:0] LIGHT_MIN = -65'sd140737488355328;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ISO   = 2'd1,
    ST_DEGEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_OFFSET = 2'd0,
    CFG_GAIN   = 2'd1,
    CFG_QUENCH = 2'd2
  } cfg_idx_e;

  // Accepted isotopes as {Z, A}.
  localparam logic [ZW+AW-1:0] ISO_HE3 = {4'd2, 7'd3};
  localparam logic [ZW+AW-1:0] ISO_HE4 = {4'd2, 7'd4};
  localparam logic [ZW+AW-1:0] ISO_HE6 = {4'd2, 7'd6};
  localparam logic [ZW+AW-1:0] ISO_LI6 = {4'd3, 7'd6};
  localparam logic [ZW+AW-1:0] ISO_LI7 = {4'd3, 7'd7};
  localparam logic [ZW+AW-1:0] ISO_LI8 = {4'd3, 7'd8};
  localparam logic [ZW+AW-1:0] ISO_BE7 = {4'd4, 7'd7};
  localparam logic [ZW+AW-1:0] ISO_BE9 = {4'd4, 7'd9};

  // Word traveling beside the datapath.
  typedef struct packed {
    status_e                status;
    logic [E16W-1:0]        e16;
    logic signed [CW-1:0]   c;
  } side_t;

  // A*Z^2 of an accepted isotope, zero for anything else.
  function automatic logic [KW-1:0] quench_weight(input logic [ZW-1:0] z,
                                                  input logic [AW-1:0] a);
    logic [KW-1:0] w;
    case ({z, a})
      ISO_HE3: w = 8'd12;
      ISO_HE4: w = 8'd16;
      ISO_HE6: w = 8'd24;
      ISO_LI6: w = 8'd54;
      ISO_LI7: w = 8'd63;
      ISO_LI8: w = 8'd72;
      ISO_BE7: w = 8'd112;
      ISO_BE9: w = 8'd144;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/horn_light_output.sv
// Top level of the scintillator light output calculator.
// Computes L = p0 + p1*(E - c*ln|(E+c)/c|) with c = p2*A*Z^2 for He-3, He-4,
// He-6, Li-6, Li-7, Li-8, Be-7 and Be-9; any other (Z, A) pair returns light 0
// with status 1, and a zero quench term or a zero log argument returns light 0
// with status 2. Energy is unsigned Q12.12, p0/p1/p2 are signed Q16.16 in
// configuration registers 0/1/2, and light is signed Q32.16, saturating. The
// block takes one word per clock while the output is not stalled and passes
// it through 4 front stages (isotope weight and quench multiply, log argument,
// coarse and fine normalization), 24 squaring stages that each produce one log
// fraction bit, and 7 back stages (log ratio, ln 2 scale, quench multiply,
// inner term, split gain multiply, recombine, offset and clamp). The whole
// pipe holds while a finished word waits at the output and the sink is not
// ready. Write configuration only while the pipe is empty.
module horn_light_output (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hlo_pkg::EW-1:0]         energy_i,
  input  logic [hlo_pkg::ZW-1:0]         charge_z_i,
  input  logic [hlo_pkg::AW-1:0]         mass_a_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [hlo_pkg::LW-1:0]  light_o,
  output logic [1:0]                     status_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [hlo_pkg::PW-1:0]         cfg_data_i
);
  import hlo_pkg::*;

  logic signed [PW-1:0] light_offset_q, light_gain_q, quench_factor_q;
  logic                 en;

  // Advance everything unless the output word is stuck.
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_offset_q  <= OFFSET_RST;
      light_gain_q    <= GAIN_RST;
      quench_factor_q <= QUENCH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET: light_offset_q  <= $signed(cfg_data_i);
        CFG_GAIN:   light_gain_q    <= $signed(cfg_data_i);
        CFG_QUENCH: quench_factor_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic            f_valid, l_valid;
  logic [MW-1:0]   m_s, m_c;
  logic [KLW-1:0]  k_s, k_c;
  logic [LGW-1:0]  log_s, log_c;
  side_t           f_side, l_side;

  hlo_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .in_valid_i      (in_valid_i),
    .energy_i        (energy_i),
    .charge_z_i      (charge_z_i),
    .mass_a_i        (mass_a_i),
    .quench_factor_i (quench_factor_q),
    .valid_o         (f_valid),
    .m_s_o           (m_s),
    .m_c_o           (m_c),
    .k_s_o           (k_s),
    .k_c_o           (k_c),
    .side_o          (f_side)
  );

  hlo_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .m_s_i   (m_s),
    .m_c_i   (m_c),
    .k_s_i   (k_s),
    .k_c_i   (k_c),
    .side_i  (f_side),
    .valid_o (l_valid),
    .log_s_o (log_s),
    .log_c_o (log_c),
    .side_o  (l_side)
  );

  hlo_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (l_valid),
    .log_s_i        (log_s),
    .log_c_i        (log_c),
    .side_i         (l_side),
    .light_offset_i (light_offset_q),
    .light_gain_i   (light_gain_q),
    .valid_o        (out_valid_o),
    .light_o        (light_o),
    .status_o       (status_o)
  );

endmodule

>>> rtl/hlo_front.sv
// Front stages: isotope check, quench term, log arguments and normalization.
module hlo_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           in_valid_i,
  input  logic [hlo_pkg::EW-1:0]         energy_i,
  input  logic [hlo_pkg::ZW-1:0]         charge_z_i,
  input  logic [hlo_pkg::AW-1:0]         mass_a_i,
  input  logic signed [hlo_pkg::PW-1:0]  quench_factor_i,
  output logic                           valid_o,
  output logic [hlo_pkg::MW-1:0]         m_s_o,
  output logic [hlo_pkg::MW-1:0]         m_c_o,
  output logic [hlo_pkg::KLW-1:0]        k_s_o,
  output logic [hlo_pkg::KLW-1:0]        k_c_o,
  output hlo_pkg::side_t                 side_o
);
  import hlo_pkg::*;

  // Coarse leading-zero steps of 32, 16 and 8.
  function automatic logic [KLW+UW-1:0] norm_hi(input logic [UW-1:0] u);
    logic [UW-1:0]  x;
    logic [KLW-1:0] n;
    x = u;
    n = '0;
    if (x[UW-1:UW-32] == '0) begin
      x = x << 32;
      n = n + 6'd32;
    end
    if (x[UW-1:UW-16] == '0) begin
      x = x << 16;
      n = n + 6'd16;
    end
    if (x[UW-1:UW-8] == '0) begin
      x = x << 8;
      n = n + 6'd8;
    end
    return {n, x};
  endfunction

  // Fine leading-zero steps of 4, 2 and 1.
  function automatic logic [KLW+UW-1:0] norm_lo(input logic [UW-1:0] u,
                                                input logic [KLW-1:0] n0);
    logic [UW-1:0]  x;
    logic [KLW-1:0] n;
    x = u;
    n = n0;
    if (x[UW-1:UW-4] == '0) begin
      x = x << 4;
      n = n + 6'd4;
    end
    if (x[UW-1:UW-2] == '0) begin
      x = x << 2;
      n = n + 6'd2;
    end
    if (x[UW-1] == 1'b0) begin
      x = x << 1;
      n = n + 6'd1;
    end
    return {n, x};
  endfunction

  logic [3:0] v_q;

  // Stage 1: weight and quench term.
  logic [KW-1:0]        weight;
  logic signed [PW+KW:0] cprod;
  side_t                side1_d, side1_q;

  assign weight = quench_weight(charge_z_i, mass_a_i);
  assign cprod  = quench_factor_i * $signed({1'b0, weight});

  always_comb begin
    side1_d.status = (weight == '0) ? ST_ISO : ST_OK;
    side1_d.e16    = {energy_i, 4'b0000};
    side1_d.c      = cprod[CW-1:0];
  end

  // Stage 2: log argument and magnitudes.
  logic signed [UW-1:0] s2, c2;
  logic [UW-1:0]        smag_d, cmag_d, smag_q, cmag_q;
  side_t                side2_d, side2_q;

  assign c2     = {side1_q.c[CW-1], side1_q.c};
  assign s2     = $signed({{(UW-E16W){1'b0}}, side1_q.e16}) + c2;
  assign smag_d = s2[UW-1] ? UW'(-s2) : UW'(s2);
  assign cmag_d = c2[UW-1] ? UW'(-c2) : UW'(c2);

  always_comb begin
    side2_d = side1_q;
    if (side1_q.status == ST_OK && (side1_q.c == '0 || s2 == '0)) begin
      side2_d.status = ST_DEGEN;
    end
  end

  // Stage 3: coarse normalization.
  logic [KLW+UW-1:0] ns3, nc3;
  logic [UW-1:0]     us3_q, uc3_q;
  logic [KLW-1:0]    ls3_q, lc3_q;
  side_t             side3_q;

  assign ns3 = norm_hi(smag_q);
  assign nc3 = norm_hi(cmag_q);

  // Stage 4: fine normalization, mantissa and exponent.
  logic [KLW+UW-1:0] ns4, nc4;
  logic [MW-1:0]     ms4_q, mc4_q;
  logic [KLW-1:0]    ks4_q, kc4_q;
  side_t             side4_q;

  assign ns4 = norm_lo(us3_q, ls3_q);
  assign nc4 = norm_lo(uc3_q, lc3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      smag_q  <= smag_d;
      cmag_q  <= cmag_d;
      side2_q <= side2_d;
      ls3_q   <= ns3[KLW+UW-1:UW];
      us3_q   <= ns3[UW-1:0];
      lc3_q   <= nc3[KLW+UW-1:UW];
      uc3_q   <= nc3[UW-1:0];
      side3_q <= side2_q;
      ms4_q   <= ns4[UW-1:UW-MW];
      mc4_q   <= nc4[UW-1:UW-MW];
      ks4_q   <= TOP_BIT - ns4[KLW+UW-1:UW];
      kc4_q   <= TOP_BIT - nc4[KLW+UW-1:UW];
      side4_q <= side3_q;
    end
  end

  assign valid_o = v_q[3];
  assign m_s_o   = ms4_q;
  assign m_c_o   = mc4_q;
  assign k_s_o   = ks4_q;
  assign k_c_o   = kc4_q;
  assign side_o  = side4_q;

endmodule

>>> rtl/hlo_log.sv
// Pipelined base-2 logarithm fraction: one squaring round per stage, two lanes.
`include "horn_light_output_defines.svh"

module hlo_log (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [hlo_pkg::MW-1:0]   m_s_i,
  input  logic [hlo_pkg::MW-1:0]   m_c_i,
  input  logic [hlo_pkg::KLW-1:0]  k_s_i,
  input  logic [hlo_pkg::KLW-1:0]  k_c_i,
  input  hlo_pkg::side_t           side_i,
  output logic                     valid_o,
  output logic [hlo_pkg::LGW-1:0]  log_s_o,
  output logic [hlo_pkg::LGW-1:0]  log_c_o,
  output hlo_pkg::side_t           side_o
);
  import hlo_pkg::*;

  logic           v_q  [ROUNDS];
  logic [MW-1:0]  ms_q [ROUNDS];
  logic [MW-1:0]  mc_q [ROUNDS];
  logic [FW-1:0]  fs_q [ROUNDS];
  logic [FW-1:0]  fc_q [ROUNDS];
  logic [KLW-1:0] ks_q [ROUNDS];
  logic [KLW-1:0] kc_q [ROUNDS];
  side_t          sd_q [ROUNDS];

  for (genvar j = 0; j < ROUNDS; j++) begin : g_round
    logic           v_in;
    logic [MW-1:0]  ms_in, mc_in;
    logic [FW-1:0]  fs_in, fc_in;
    logic [KLW-1:0] ks_in, kc_in;
    side_t          sd_in;
    logic [2*MW-1:0] sq_s, sq_c;
    logic [MW:0]     t_s, t_c;

    if (j == 0) begin : g_first
      assign v_in  = valid_i;
      assign ms_in = m_s_i;
      assign mc_in = m_c_i;
      assign fs_in = '0;
      assign fc_in = '0;
      assign ks_in = k_s_i;
      assign kc_in = k_c_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = v_q[j-1];
      assign ms_in = ms_q[j-1];
      assign mc_in = mc_q[j-1];
      assign fs_in = fs_q[j-1];
      assign fc_in = fc_q[j-1];
      assign ks_in = ks_q[j-1];
      assign kc_in = kc_q[j-1];
      assign sd_in = sd_q[j-1];
    end

    // Square in Q1.31; a result of two or more yields a one bit and halves.
    assign sq_s = ms_in * ms_in;
    assign sq_c = mc_in * mc_in;
    assign t_s  = sq_s[2*MW-1:MW-1];
    assign t_c  = sq_c[2*MW-1:MW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ms_q[j] <= t_s[MW] ? t_s[MW:1] : t_s[MW-1:0];
        mc_q[j] <= t_c[MW] ? t_c[MW:1] : t_c[MW-1:0];
        fs_q[j] <= {fs_in[FW-2:0], t_s[MW]};
        fc_q[j] <= {fc_in[FW-2:0], t_c[MW]};
        ks_q[j] <= ks_in;
        kc_q[j] <= kc_in;
        sd_q[j] <= sd_in;
      end
    end
  end

  assign valid_o = v_q[ROUNDS-1];
  assign log_s_o = {ks_q[ROUNDS-1], fs_q[ROUNDS-1]};
  assign log_c_o = {kc_q[ROUNDS-1], fc_q[ROUNDS-1]};
  assign side_o  = sd_q[ROUNDS-1];

  // Mantissas are still normalized after the last round.
  `HLO_ASSERT(a_mant_norm, clk_i, rst_ni, v_q[ROUNDS-1] && sd_q[ROUNDS-1].status == ST_OK |-> ms_q[ROUNDS-1][MW-1] && mc_q[ROUNDS-1][MW-1])
  // Exponents fit the log argument width.
  `HLO_ASSERT(a_exp_range, clk_i, rst_ni, v_q[ROUNDS-1] && sd_q[ROUNDS-1].status == ST_OK |-> ks_q[ROUNDS-1] <= TOP_BIT && kc_q[ROUNDS-1] <= TOP_BIT)
  // A stall freezes the last stage.
  `HLO_ASSERT(a_stall_hold, clk_i, rst_ni, !en_i |=> $stable(v_q[ROUNDS-1]) && $stable(fs_q[ROUNDS-1]))

endmodule

>>> rtl/hlo_back.sv
// Back stages: log ratio, quench correction, gain, offset and saturation.
module hlo_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [hlo_pkg::LGW-1:0]        log_s_i,
  input  logic [hlo_pkg::LGW-1:0]        log_c_i,
  input  hlo_pkg::side_t                 side_i,
  input  logic signed [hlo_pkg::PW-1:0]  light_offset_i,
  input  logic signed [hlo_pkg::PW-1:0]  light_gain_i,
  output logic                           valid_o,
  output logic signed [hlo_pkg::LW-1:0]  light_o,
  output logic [1:0]                     status_o
);
  import hlo_pkg::*;

  logic [6:0] v_q;
  side_t      sd1_q, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q;

  // Stage 1: log2 ratio.
  logic signed [DW-1:0] d_q;

  // Stage 2: scale by ln 2, floor to Q.16.
  logic signed [2*DW-1:0] lnp;
  logic signed [LNW-1:0]  lnq_q;
  assign lnp = d_q * LN2_Q30;

  // Stage 3: c times ln ratio, floor to Q.16.
  logic signed [CW+LNW-1:0] ltp;
  logic signed [LW-1:0]     lt_q;
  assign ltp = sd2_q.c * lnq_q;

  // Stage 4: inner term, split into sign and magnitude.
  logic signed [IW-1:0] inner;
  logic [IW-1:0]        mi_q;
  logic [PW-1:0]        mp_q;
  logic                 neg4_q;
  assign inner = $signed({{(IW-E16W){1'b0}}, sd3_q.e16}) - {lt_q[LW-1], lt_q};

  // Stage 5: partial products.
  logic [2*PW-1:0]      plo_q;
  logic [PW+IW-33:0]    phi_q;
  logic                 neg5_q;

  // Stage 6: recombine and apply sign.
  logic [63:0]          prod;
  logic signed [63:0]   part_q;
  assign prod = (64'(phi_q) << 16) + {16'b0, plo_q[2*PW-1:16]};

  // Stage 7: offset and clamp.
  logic signed [LW+16:0] sum;
  logic signed [LW-1:0]  light_d, light_q;
  status_e               status_q;
  assign sum = {{(LW-PW+17){light_offset_i[PW-1]}}, light_offset_i} + {part_q[63], part_q};

  always_comb begin
    if (sd6_q.status != ST_OK) begin
      light_d = '0;
    end else if (sum > LIGHT_MAX) begin
      light_d = LIGHT_MAX[LW-1:0];
    end else if (sum < LIGHT_MIN) begin
      light_d = LIGHT_MIN[LW-1:0];
    end else begin
      light_d = sum[LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q      <= $signed({1'b0, log_s_i}) - $signed({1'b0, log_c_i});
      sd1_q    <= side_i;
      lnq_q    <= lnp[2*DW-1:38];
      sd2_q    <= sd1_q;
      lt_q     <= ltp[CW+LNW-1:16];
      sd3_q    <= sd2_q;
      mi_q     <= inner[IW-1] ? IW'(-inner) : IW'(inner);
      mp_q     <= light_gain_i[PW-1] ? PW'(-light_gain_i) : PW'(light_gain_i);
      neg4_q   <= light_gain_i[PW-1] != inner[IW-1];
      sd4_q    <= sd3_q;
      plo_q    <= mp_q * mi_q[31:0];
      phi_q    <= mp_q * mi_q[IW-1:32];
      neg5_q   <= neg4_q;
      sd5_q    <= sd4_q;
      part_q   <= neg5_q ? -$signed(prod) : $signed(prod);
      sd6_q    <= sd5_q;
      light_q  <= light_d;
      status_q <= sd6_q.status;
    end
  end

  assign valid_o  = v_q[6];
  assign light_o  = light_q;
  assign status_o = status_q;

endmodule
